// ===== rtl/acfm_pkg.sv =====
// ----------------------------------------------------------------------------
// acfm_pkg
// Shared widths, codes and control records of the cumulative frequency model.
// ----------------------------------------------------------------------------
package acfm_pkg;

  localparam int unsigned NumSymbolsDef = 257;
  localparam int unsigned SymW   = 9;
  localparam int unsigned ValW   = 32;
  localparam int unsigned SumW   = 40;
  localparam int unsigned ScaleW = 30;
  localparam int unsigned ActW   = 2;
  localparam int unsigned StW    = 2;
  localparam int unsigned ProdW  = 64;

  localparam logic [ScaleW-1:0] ScaleRst = 30'd65535;
  localparam logic [ValW-1:0]   MinRange = 32'd2;

  typedef enum logic [ActW-1:0] {
    ACT_LOAD   = 2'd0,
    ACT_BUILD  = 2'd1,
    ACT_RANGE  = 2'd2,
    ACT_DECODE = 2'd3
  } action_e;

  typedef enum logic [StW-1:0] {
    ST_OK        = 2'd0,
    ST_ZERO_SUM  = 2'd1,
    ST_NOT_BUILT = 2'd2
  } status_e;

  typedef struct packed {
    logic    cap_in;
    logic    ld_rd;
    logic    ld_wr;
    logic    bld_fail;
    logic    bld_init;
    logic    bld_rd;
    logic    bld_mul;
    logic    bld_acc;
    logic    div_start;
    logic    div_dec;
    logic    dec_mul;
    logic    key_zero;
    logic    key_ld;
    logic    srch_rd;
    logic    srch_cmp;
    logic    srch_fin;
    logic    q_rd0;
    logic    q_rd1;
    logic    q_cap;
    logic    set_st;
    status_e st;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    action_e action;
    logic    sym_ok;
    logic    sum_zero;
    logic    tbl_ready;
    logic    w_last;
    logic    span_zero;
    logic    prod_zero;
    logic    div_done;
  } sts_t;

endpackage

// ===== rtl/arith_coder_cumfreq_model.sv =====
// ----------------------------------------------------------------------------
// arith_coder_cumfreq_model
// Static cumulative frequency model for an arithmetic coder.
//
// Input beats carry an action: load a symbol count, build the cumulative
// table, query a symbol's range, or decode a symbol from a code value.
// Each input beat yields exactly one output beat on the valid/ready result
// channel. The user must write the scale register through cfg_we_i only
// while idle; the block itself does not enforce this. One item is in
// flight at a time; in_ready_o rises again once its result sits in the
// output register, so a new beat is taken while the receiver stalls, and
// its result holds until the previous one is taken. A build runs one divide
// per symbol; a decode runs a divide, skipped for a zero product, then a
// binary search. The divider yields one quotient bit per cycle.
// Reset clears the counts (valid bits), the running sum and the built flag.
// ----------------------------------------------------------------------------
module arith_coder_cumfreq_model #(
  parameter int unsigned NUM_SYMBOLS = acfm_pkg::NumSymbolsDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [acfm_pkg::ScaleW-1:0] cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [acfm_pkg::ActW-1:0]   action_i,
  input  logic [acfm_pkg::SymW-1:0]   symbol_i,
  input  logic [acfm_pkg::ValW-1:0]   count_i,
  input  logic [acfm_pkg::ValW-1:0]   code_value_i,
  input  logic [acfm_pkg::ValW-1:0]   interval_low_i,
  input  logic [acfm_pkg::ValW-1:0]   interval_high_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [acfm_pkg::StW-1:0]    status_o,
  output logic [acfm_pkg::ValW-1:0]   range_begin_o,
  output logic [acfm_pkg::ValW-1:0]   range_finish_o,
  output logic [acfm_pkg::ValW-1:0]   grand_total_o,
  output logic [acfm_pkg::SymW-1:0]   found_symbol_o
);

  acfm_pkg::cmd_t cmd;
  acfm_pkg::sts_t sts;

  acfm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  acfm_dp #(
    .NUM_SYMBOLS(NUM_SYMBOLS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .action_i       (action_i),
    .symbol_i       (symbol_i),
    .count_i        (count_i),
    .code_value_i   (code_value_i),
    .interval_low_i (interval_low_i),
    .interval_high_i(interval_high_i),
    .status_o       (status_o),
    .range_begin_o  (range_begin_o),
    .range_finish_o (range_finish_o),
    .grand_total_o  (grand_total_o),
    .found_symbol_o (found_symbol_o)
  );

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while an item is in flight");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o == acfm_pkg::ST_OK) || (status_o == acfm_pkg::ST_ZERO_SUM)
                    || (status_o == acfm_pkg::ST_NOT_BUILT))
    else $error("unknown status code");

  a_found_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> 32'(found_symbol_o) < NUM_SYMBOLS)
    else $error("decoded symbol out of range");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == acfm_pkg::ST_NOT_BUILT) |->
      (range_begin_o == '0) && (grand_total_o == '0) && (found_symbol_o == '0))
    else $error("error result carries data");

endmodule

// ===== rtl/acfm_div.sv =====
// ----------------------------------------------------------------------------
// acfm_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module acfm_div #(
  parameter int unsigned DW = acfm_pkg::ProdW,
  parameter int unsigned VW = acfm_pkg::SumW
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [VW-1:0] divisor_i,
  output logic          done_o,
  output logic [DW-1:0] quot_o
);

  localparam int unsigned CW = $clog2(DW);

  logic          busy_q;
  logic          done_q;
  logic [CW-1:0] cnt_q;
  logic [DW-1:0] quo_q;
  logic [VW-1:0] rem_q;
  logic [VW-1:0] dvs_q;
  logic [VW:0]   rem_sh;
  logic [VW:0]   rem_n;
  logic          ge;

  assign rem_sh = {rem_q, quo_q[DW-1]};
  assign ge     = rem_sh >= {1'b0, dvs_q};
  assign rem_n  = ge ? rem_sh - {1'b0, dvs_q} : rem_sh;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CW'(DW - 1);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[DW-2:0], ge};
      rem_q <= rem_n[VW-1:0];
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

// ===== rtl/acfm_dp.sv =====
// ----------------------------------------------------------------------------
// acfm_dp
// Datapath: count and cumulative stores, multiplier, divider, search pointers.
// ----------------------------------------------------------------------------
module acfm_dp #(
  parameter int unsigned NUM_SYMBOLS = acfm_pkg::NumSymbolsDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  acfm_pkg::cmd_t              cmd_i,
  output acfm_pkg::sts_t              sts_o,
  input  logic                        cfg_we_i,
  input  logic [acfm_pkg::ScaleW-1:0] cfg_wdata_i,
  input  logic [acfm_pkg::ActW-1:0]   action_i,
  input  logic [acfm_pkg::SymW-1:0]   symbol_i,
  input  logic [acfm_pkg::ValW-1:0]   count_i,
  input  logic [acfm_pkg::ValW-1:0]   code_value_i,
  input  logic [acfm_pkg::ValW-1:0]   interval_low_i,
  input  logic [acfm_pkg::ValW-1:0]   interval_high_i,
  output logic [acfm_pkg::StW-1:0]    status_o,
  output logic [acfm_pkg::ValW-1:0]   range_begin_o,
  output logic [acfm_pkg::ValW-1:0]   range_finish_o,
  output logic [acfm_pkg::ValW-1:0]   grand_total_o,
  output logic [acfm_pkg::SymW-1:0]   found_symbol_o
);

  localparam int unsigned IW  = $clog2(NUM_SYMBOLS + 1);
  localparam int unsigned CIW = $clog2(NUM_SYMBOLS);
  localparam int unsigned SPW = $clog2(NUM_SYMBOLS + 2);
  localparam int unsigned VW  = acfm_pkg::ValW;

  logic [acfm_pkg::ActW-1:0]   act_q;
  logic [acfm_pkg::SymW-1:0]   sym_q;
  logic [VW-1:0]               cin_q;
  logic [VW-1:0]               val_q;
  logic [VW-1:0]               lo_q;
  logic [VW-1:0]               hi_q;
  logic [acfm_pkg::ScaleW-1:0] scale_q;
  logic [acfm_pkg::SumW-1:0]   sum_q;
  logic                        rdy_q;
  logic [VW-1:0]               total_q;
  logic [IW-1:0]               w_q;
  logic [VW-1:0]               acc_q;
  logic [acfm_pkg::ProdW-1:0]  prod_q;
  logic [acfm_pkg::ProdW-1:0]  key_q;
  logic [IW-1:0]               first_q;
  logic [SPW-1:0]              span_q;
  logic [IW-1:0]               qidx_q;
  logic [VW-1:0]               wk_begin_q;
  logic [VW-1:0]               wk_finish_q;
  logic [VW-1:0]               wk_gt_q;
  logic [acfm_pkg::SymW-1:0]   wk_found_q;
  logic [acfm_pkg::StW-1:0]    wk_st_q;
  logic [acfm_pkg::StW-1:0]    out_st_q;
  logic [VW-1:0]               out_begin_q;
  logic [VW-1:0]               out_finish_q;
  logic [VW-1:0]               out_gt_q;
  logic [acfm_pkg::SymW-1:0]   out_found_q;

  logic [VW-1:0]          cnt_mem [NUM_SYMBOLS];
  logic [NUM_SYMBOLS-1:0] cnt_vld_q;
  logic [VW-1:0]          cnt_rd_q;
  logic                   cnt_rv_q;
  logic [VW-1:0]          cum_mem [NUM_SYMBOLS+1];
  logic [VW-1:0]          cum_rd_q;

  logic [CIW-1:0]             cnt_addr;
  logic [VW-1:0]              cnt_val;
  logic [IW-1:0]              cum_raddr;
  logic [IW-1:0]              cum_waddr;
  logic                       cum_we;
  logic [VW-1:0]              cum_wdata;
  logic [VW-1:0]              mul_op;
  logic [61:0]                prod_b;
  logic [VW-1:0]              dlt;
  logic [acfm_pkg::ProdW-1:0] dmul;
  logic [acfm_pkg::ProdW-1:0] prod_d;
  logic [VW:0]                width;
  logic [acfm_pkg::ProdW-1:0] div_dvd;
  logic [acfm_pkg::SumW-1:0]  div_dvs;
  logic                       div_done;
  logic [acfm_pkg::ProdW-1:0] quot;
  logic [VW-1:0]              rng;
  logic [VW-1:0]              acc_n;
  logic [SPW-1:0]             half;
  logic [IW-1:0]              probe;
  logic                       key_lt;
  logic [IW-1:0]              srch_res;
  logic [IW-1:0]              sym_clamp;
  logic                       w_last;

  assign w_last   = w_q == IW'(NUM_SYMBOLS - 1);
  assign cnt_addr = cmd_i.ld_rd ? CIW'(sym_q) : w_q[CIW-1:0];
  assign cnt_val  = cnt_rv_q ? cnt_rd_q : '0;

  assign half  = span_q >> 1;
  assign probe = first_q + IW'(half);
  assign key_lt = (key_q[acfm_pkg::ProdW-1:VW] == '0) && (key_q[VW-1:0] < cum_rd_q);

  always_comb begin
    if (first_q == '0) begin
      srch_res = '0;
    end else begin
      srch_res = first_q - 1'b1;
    end
    if (32'(srch_res) > NUM_SYMBOLS - 1) begin
      srch_res = IW'(NUM_SYMBOLS - 1);
    end
  end

  assign sym_clamp = (32'(symbol_i) > NUM_SYMBOLS - 1) ? IW'(NUM_SYMBOLS - 1) : IW'(symbol_i);

  always_comb begin
    if (cmd_i.srch_rd) begin
      cum_raddr = probe;
    end else if (cmd_i.q_rd1) begin
      cum_raddr = qidx_q + 1'b1;
    end else begin
      cum_raddr = qidx_q;
    end
  end

  assign rng   = (quot[acfm_pkg::ProdW-1:1] == '0) ? acfm_pkg::MinRange : quot[VW-1:0];
  assign acc_n = acc_q + rng;

  assign cum_we    = cmd_i.bld_init | cmd_i.bld_acc;
  assign cum_waddr = cmd_i.bld_init ? '0 : w_q + 1'b1;
  assign cum_wdata = cmd_i.bld_init ? '0 : acc_n;

  assign mul_op = w_last ? VW'(1) : cnt_val;
  assign prod_b = mul_op * scale_q;
  assign dlt    = val_q - lo_q;
  assign dmul   = dlt * total_q;
  assign prod_d = cmd_i.dec_mul ? dmul + acfm_pkg::ProdW'(total_q)
                                : acfm_pkg::ProdW'(prod_b);

  assign width   = {1'b0, hi_q - lo_q} + 1'b1;
  assign div_dvd = cmd_i.div_dec ? prod_q - 1'b1 : prod_q;
  assign div_dvs = cmd_i.div_dec ? acfm_pkg::SumW'(width) : sum_q;

  acfm_div #(
    .DW(acfm_pkg::ProdW),
    .VW(acfm_pkg::SumW)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (cmd_i.div_start),
    .dividend_i(div_dvd),
    .divisor_i (div_dvs),
    .done_o    (div_done),
    .quot_o    (quot)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_wr) begin
      cnt_mem[CIW'(sym_q)] <= cin_q;
    end
    cnt_rd_q <= cnt_mem[cnt_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cum_we) begin
      cum_mem[cum_waddr] <= cum_wdata;
    end
    cum_rd_q <= cum_mem[cum_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_vld_q <= '0;
      cnt_rv_q  <= 1'b0;
      scale_q   <= acfm_pkg::ScaleRst;
      sum_q     <= '0;
      rdy_q     <= 1'b0;
      total_q   <= '0;
    end else begin
      cnt_rv_q <= cnt_vld_q[cnt_addr];
      if (cmd_i.ld_wr) begin
        cnt_vld_q[CIW'(sym_q)] <= 1'b1;
        sum_q <= sum_q - acfm_pkg::SumW'(cnt_val) + acfm_pkg::SumW'(cin_q);
      end
      if (cfg_we_i) begin
        scale_q <= cfg_wdata_i;
      end
      if (cmd_i.bld_fail) begin
        rdy_q <= 1'b0;
      end else if (cmd_i.bld_acc && w_last) begin
        rdy_q   <= 1'b1;
        total_q <= acc_n;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_in) begin
      act_q       <= action_i;
      sym_q       <= symbol_i;
      cin_q       <= count_i;
      val_q       <= code_value_i;
      lo_q        <= interval_low_i;
      hi_q        <= interval_high_i;
      qidx_q      <= sym_clamp;
      wk_begin_q  <= '0;
      wk_finish_q <= '0;
      wk_gt_q     <= '0;
      wk_found_q  <= '0;
      wk_st_q     <= acfm_pkg::ST_OK;
    end
    if (cmd_i.set_st) begin
      wk_st_q <= cmd_i.st;
    end
    if (cmd_i.bld_init) begin
      w_q   <= '0;
      acc_q <= '0;
    end
    if (cmd_i.bld_acc) begin
      w_q   <= w_q + 1'b1;
      acc_q <= acc_n;
      if (w_last) begin
        wk_gt_q <= acc_n;
      end
    end
    if (cmd_i.bld_mul || cmd_i.dec_mul) begin
      prod_q <= prod_d;
    end
    if (cmd_i.dec_mul) begin
      first_q <= '0;
      span_q  <= SPW'(NUM_SYMBOLS + 1);
    end
    if (cmd_i.key_zero) begin
      key_q <= '0;
    end else if (cmd_i.key_ld) begin
      key_q <= quot;
    end
    if (cmd_i.srch_cmp) begin
      if (!key_lt) begin
        first_q <= probe + 1'b1;
        span_q  <= span_q - half - 1'b1;
      end else begin
        span_q <= half;
      end
    end
    if (cmd_i.srch_fin) begin
      qidx_q     <= srch_res;
      wk_found_q <= acfm_pkg::SymW'(srch_res);
    end
    if (cmd_i.q_rd1) begin
      wk_begin_q <= cum_rd_q;
    end
    if (cmd_i.q_cap) begin
      wk_finish_q <= cum_rd_q;
      wk_gt_q     <= total_q;
    end
    if (cmd_i.out_load) begin
      out_st_q     <= wk_st_q;
      out_begin_q  <= wk_begin_q;
      out_finish_q <= wk_finish_q;
      out_gt_q     <= wk_gt_q;
      out_found_q  <= wk_found_q;
    end
  end

  assign sts_o.action    = acfm_pkg::action_e'(act_q);
  assign sts_o.sym_ok    = 32'(sym_q) < NUM_SYMBOLS;
  assign sts_o.sum_zero  = sum_q == '0;
  assign sts_o.tbl_ready = rdy_q;
  assign sts_o.w_last    = w_last;
  assign sts_o.span_zero = span_q == '0;
  assign sts_o.prod_zero = prod_q == '0;
  assign sts_o.div_done  = div_done;

  assign status_o       = out_st_q;
  assign range_begin_o  = out_begin_q;
  assign range_finish_o = out_finish_q;
  assign grand_total_o  = out_gt_q;
  assign found_symbol_o = out_found_q;

endmodule

// ===== rtl/acfm_ctrl.sv =====
// ----------------------------------------------------------------------------
// acfm_ctrl
// Sequencer for load, build, range and decode actions; owns the handshakes.
// ----------------------------------------------------------------------------
module acfm_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  input  acfm_pkg::sts_t sts_i,
  output acfm_pkg::cmd_t cmd_o
);

  typedef enum logic [18:0] {
    S_IDLE  = 19'd1,
    S_DISP  = 19'd2,
    S_LD_RD = 19'd4,
    S_LD_WR = 19'd8,
    S_B_RD  = 19'd16,
    S_B_MUL = 19'd32,
    S_B_DST = 19'd64,
    S_B_DIV = 19'd128,
    S_B_ACC = 19'd256,
    S_D_MUL = 19'd512,
    S_D_DST = 19'd1024,
    S_D_DIV = 19'd2048,
    S_S_RD  = 19'd4096,
    S_S_CMP = 19'd8192,
    S_S_FIN = 19'd16384,
    S_Q_RD0 = 19'd32768,
    S_Q_RD1 = 19'd65536,
    S_Q_CAP = 19'd131072,
    S_DONE  = 19'd262144
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q;
  logic   out_free;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = state_q == S_IDLE;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.st = acfm_pkg::ST_OK;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.cap_in = 1'b1;
          state_d = S_DISP;
        end
      end
      S_DISP: begin
        case (sts_i.action)
          acfm_pkg::ACT_LOAD: begin
            state_d = sts_i.sym_ok ? S_LD_RD : S_DONE;
          end
          acfm_pkg::ACT_BUILD: begin
            if (sts_i.sum_zero) begin
              cmd_o.bld_fail = 1'b1;
              cmd_o.set_st   = 1'b1;
              cmd_o.st       = acfm_pkg::ST_ZERO_SUM;
              state_d = S_DONE;
            end else begin
              cmd_o.bld_init = 1'b1;
              state_d = S_B_RD;
            end
          end
          acfm_pkg::ACT_RANGE, acfm_pkg::ACT_DECODE: begin
            if (!sts_i.tbl_ready) begin
              cmd_o.set_st = 1'b1;
              cmd_o.st     = acfm_pkg::ST_NOT_BUILT;
              state_d = S_DONE;
            end else if (sts_i.action == acfm_pkg::ACT_RANGE) begin
              state_d = S_Q_RD0;
            end else begin
              state_d = S_D_MUL;
            end
          end
          default: state_d = S_DONE;
        endcase
      end
      S_LD_RD: begin
        cmd_o.ld_rd = 1'b1;
        state_d = S_LD_WR;
      end
      S_LD_WR: begin
        cmd_o.ld_wr = 1'b1;
        state_d = S_DONE;
      end
      S_B_RD: begin
        cmd_o.bld_rd = 1'b1;
        state_d = S_B_MUL;
      end
      S_B_MUL: begin
        cmd_o.bld_mul = 1'b1;
        state_d = S_B_DST;
      end
      S_B_DST: begin
        cmd_o.div_start = 1'b1;
        state_d = S_B_DIV;
      end
      S_B_DIV: begin
        if (sts_i.div_done) begin
          state_d = S_B_ACC;
        end
      end
      S_B_ACC: begin
        cmd_o.bld_acc = 1'b1;
        state_d = sts_i.w_last ? S_DONE : S_B_RD;
      end
      S_D_MUL: begin
        cmd_o.dec_mul = 1'b1;
        state_d = S_D_DST;
      end
      S_D_DST: begin
        if (sts_i.prod_zero) begin
          cmd_o.key_zero = 1'b1;
          state_d = S_S_RD;
        end else begin
          cmd_o.div_start = 1'b1;
          cmd_o.div_dec   = 1'b1;
          state_d = S_D_DIV;
        end
      end
      S_D_DIV: begin
        if (sts_i.div_done) begin
          cmd_o.key_ld = 1'b1;
          state_d = S_S_RD;
        end
      end
      S_S_RD: begin
        if (sts_i.span_zero) begin
          state_d = S_S_FIN;
        end else begin
          cmd_o.srch_rd = 1'b1;
          state_d = S_S_CMP;
        end
      end
      S_S_CMP: begin
        cmd_o.srch_cmp = 1'b1;
        state_d = S_S_RD;
      end
      S_S_FIN: begin
        cmd_o.srch_fin = 1'b1;
        state_d = S_Q_RD0;
      end
      S_Q_RD0: begin
        cmd_o.q_rd0 = 1'b1;
        state_d = S_Q_RD1;
      end
      S_Q_RD1: begin
        cmd_o.q_rd1 = 1'b1;
        state_d = S_Q_CAP;
      end
      S_Q_CAP: begin
        cmd_o.q_cap = 1'b1;
        state_d = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cmd_o.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== bench/arith_coder_cumfreq_model_chk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arith_coder_cumfreq_model_chk
// Watches the input, result and scale ports of the cumulative frequency
// model, keeps its own copy of counts, sum and table, predicts one result per
// input beat and compares every result beat field by field, oldest first.
// ----------------------------------------------------------------------------
module arith_coder_cumfreq_model_chk (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [acfm_pkg::ScaleW-1:0] cfg_wdata_i,
  input  logic                        in_valid_i,
  input  logic                        in_ready_i,
  input  logic [acfm_pkg::ActW-1:0]   action_i,
  input  logic [acfm_pkg::SymW-1:0]   symbol_i,
  input  logic [acfm_pkg::ValW-1:0]   count_i,
  input  logic [acfm_pkg::ValW-1:0]   code_value_i,
  input  logic [acfm_pkg::ValW-1:0]   interval_low_i,
  input  logic [acfm_pkg::ValW-1:0]   interval_high_i,
  input  logic                        out_valid_i,
  input  logic                        out_ready_i,
  input  logic [acfm_pkg::StW-1:0]    status_i,
  input  logic [acfm_pkg::ValW-1:0]   range_begin_i,
  input  logic [acfm_pkg::ValW-1:0]   range_finish_i,
  input  logic [acfm_pkg::ValW-1:0]   grand_total_i,
  input  logic [acfm_pkg::SymW-1:0]   found_symbol_i,
  output int                          pending_o,
  output int                          errors_o
);

  localparam int unsigned NSym = acfm_pkg::NumSymbolsDef;

  typedef struct packed {
    acfm_pkg::status_e             st;
    logic [acfm_pkg::ValW-1:0]     start_v;
    logic [acfm_pkg::ValW-1:0]     stop_v;
    logic [acfm_pkg::ValW-1:0]     total_v;
    logic [acfm_pkg::SymW-1:0]     sym_v;
  } model_res_t;

  logic [acfm_pkg::ValW-1:0]   counts_q [NSym];
  logic [acfm_pkg::SumW-1:0]   count_total;
  logic [acfm_pkg::ValW-1:0]   cum_tbl [NSym+1];
  logic                        tbl_built;
  logic [acfm_pkg::ScaleW-1:0] scale_q;
  model_res_t                  expected_q[$];

  function automatic logic [acfm_pkg::SymW-1:0] find_symbol(logic [63:0] key);
    int unsigned first, span, half, probe;
    first = 0;
    span  = NSym + 1;
    while (span > 0) begin
      half  = span / 2;
      probe = first + half;
      if (!(key < {32'b0, cum_tbl[probe]})) begin
        first = probe + 1;
        span  = span - half - 1;
      end else begin
        span = half;
      end
    end
    if (first == 0) return '0;
    first = first - 1;
    if (first > NSym - 1) first = NSym - 1;
    return first[acfm_pkg::SymW-1:0];
  endfunction

  function automatic model_res_t predict_beat(acfm_pkg::action_e act,
                                             logic [acfm_pkg::SymW-1:0] sym,
                                             logic [acfm_pkg::ValW-1:0] cnt,
                                             logic [acfm_pkg::ValW-1:0] val,
                                             logic [acfm_pkg::ValW-1:0] lo,
                                             logic [acfm_pkg::ValW-1:0] hi);
    model_res_t  r;
    logic [63:0] part, width, off, prod, key;
    logic [acfm_pkg::ValW-1:0] acc;
    int unsigned idx;
    r = '0;
    r.st = acfm_pkg::ST_OK;
    case (act)
      acfm_pkg::ACT_LOAD: begin
        if (sym < NSym) begin
          count_total = count_total - {8'b0, counts_q[sym]} + {8'b0, cnt};
          counts_q[sym] = cnt;
        end
      end
      acfm_pkg::ACT_BUILD: begin
        if (count_total == '0) begin
          tbl_built = 1'b0;
          r.st = acfm_pkg::ST_ZERO_SUM;
        end else begin
          acc = '0;
          cum_tbl[0] = '0;
          for (int w = 0; w < NSym - 1; w++) begin
            part = ({32'b0, counts_q[w]} * {34'b0, scale_q}) / {24'b0, count_total};
            if (part < 2) part = 2;
            acc = acc + part[acfm_pkg::ValW-1:0];
            cum_tbl[w+1] = acc;
          end
          part = {34'b0, scale_q} / {24'b0, count_total};
          if (part < 2) part = 2;
          acc = acc + part[acfm_pkg::ValW-1:0];
          cum_tbl[NSym] = acc;
          tbl_built = 1'b1;
          r.total_v = acc;
        end
      end
      default: begin
        if (!tbl_built) begin
          r.st = acfm_pkg::ST_NOT_BUILT;
        end else begin
          if (act == acfm_pkg::ACT_RANGE) begin
            idx = (sym > NSym - 1) ? NSym - 1 : sym;
          end else begin
            width = {32'b0, hi - lo} + 64'd1;
            off   = {32'b0, val - lo} + 64'd1;
            prod  = off * {32'b0, cum_tbl[NSym]};
            key   = (prod == 0) ? 64'd0 : (prod - 64'd1) / width;
            r.sym_v = find_symbol(key);
            idx = r.sym_v;
          end
          r.start_v = cum_tbl[idx];
          r.stop_v  = cum_tbl[idx+1];
          r.total_v = cum_tbl[NSym];
        end
      end
    endcase
    return r;
  endfunction

  task automatic report(string name, logic [63:0] exp_v, logic [63:0] act_v);
    $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
    errors_o++;
  endtask

  assign pending_o = expected_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    model_res_t e;
    if (!rst_ni) begin
      for (int i = 0; i < NSym; i++) counts_q[i] = '0;
      for (int i = 0; i <= NSym; i++) cum_tbl[i] = '0;
      count_total = '0;
      tbl_built   = 1'b0;
      scale_q     = acfm_pkg::ScaleRst;
      errors_o    = 0;
      expected_q.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_q.size() == 0) begin
          $display("%0t: result beat with nothing expected, status %0d", $time, status_i);
          errors_o++;
        end else begin
          e = expected_q.pop_front();
          if (status_i != e.st) report("status", e.st, status_i);
          if (range_begin_i != e.start_v) report("range_begin", e.start_v, range_begin_i);
          if (range_finish_i != e.stop_v) report("range_finish", e.stop_v, range_finish_i);
          if (grand_total_i != e.total_v) report("grand_total", e.total_v, grand_total_i);
          if (found_symbol_i != e.sym_v) report("found_symbol", e.sym_v, found_symbol_i);
        end
      end
      if (in_valid_i && in_ready_i)
        expected_q.push_back(predict_beat(acfm_pkg::action_e'(action_i), symbol_i, count_i,
                                          code_value_i, interval_low_i, interval_high_i));
      if (cfg_we_i) scale_q = cfg_wdata_i;
    end
  end

endmodule

// ===== bench/arith_coder_cumfreq_model_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arith_coder_cumfreq_model_tb
// Drives load, build, range and decode beats into the cumulative frequency
// model under several scale settings, with random gaps and result stalls,
// and reports the verdict from the checker's failure and pending counts.
// ----------------------------------------------------------------------------
module arith_coder_cumfreq_model_tb;

  localparam int unsigned NSym = acfm_pkg::NumSymbolsDef;

  logic                        clk_i = 1'b0;
  logic                        rst_ni = 1'b0;
  logic                        cfg_we = 1'b0;
  logic [acfm_pkg::ScaleW-1:0] cfg_wdata = '0;
  logic                        in_valid = 1'b0;
  logic                        in_ready;
  logic [acfm_pkg::ActW-1:0]   action = acfm_pkg::ACT_LOAD;
  logic [acfm_pkg::SymW-1:0]   symbol = '0;
  logic [acfm_pkg::ValW-1:0]   count = '0;
  logic [acfm_pkg::ValW-1:0]   code_value = '0;
  logic [acfm_pkg::ValW-1:0]   interval_low = '0;
  logic [acfm_pkg::ValW-1:0]   interval_high = '0;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  logic [acfm_pkg::StW-1:0]    status;
  logic [acfm_pkg::ValW-1:0]   range_begin, range_finish, grand_total;
  logic [acfm_pkg::SymW-1:0]   found_symbol;
  int                          pending, errors;
  int                          out_beats;
  int                          seg_left;
  logic                        seg_ready;
  logic                        long_hold_done;

  always #5 clk_i = ~clk_i;

  arith_coder_cumfreq_model i_dut (
    .clk_i, .rst_ni,
    .cfg_we_i(cfg_we), .cfg_wdata_i(cfg_wdata),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .action_i(action), .symbol_i(symbol), .count_i(count),
    .code_value_i(code_value), .interval_low_i(interval_low),
    .interval_high_i(interval_high),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .status_o(status), .range_begin_o(range_begin), .range_finish_o(range_finish),
    .grand_total_o(grand_total), .found_symbol_o(found_symbol)
  );

  arith_coder_cumfreq_model_chk i_chk (
    .clk_i, .rst_ni,
    .cfg_we_i(cfg_we), .cfg_wdata_i(cfg_wdata),
    .in_valid_i(in_valid), .in_ready_i(in_ready),
    .action_i(action), .symbol_i(symbol), .count_i(count),
    .code_value_i(code_value), .interval_low_i(interval_low),
    .interval_high_i(interval_high),
    .out_valid_i(out_valid), .out_ready_i(out_ready),
    .status_i(status), .range_begin_i(range_begin), .range_finish_i(range_finish),
    .grand_total_i(grand_total), .found_symbol_i(found_symbol),
    .pending_o(pending), .errors_o(errors)
  );

  // result side: random ready segments, one long hold-off after 200 beats
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
      out_beats <= 0;
      seg_left <= 0;
      seg_ready <= 1'b1;
      long_hold_done <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_beats <= out_beats + 1;
      if (!long_hold_done && out_beats >= 200 && in_valid) begin
        long_hold_done <= 1'b1;
        seg_left <= 400;
        seg_ready <= 1'b0;
        out_ready <= 1'b0;
      end else if (seg_left > 0) begin
        seg_left <= seg_left - 1;
        out_ready <= seg_ready;
      end else begin
        case ($urandom_range(0, 9))
          0: begin seg_ready <= 1'b0; seg_left <= $urandom_range(15, 60); end
          1: begin seg_ready <= 1'b1; seg_left <= $urandom_range(50, 200); end
          default: begin
            seg_ready <= ($urandom_range(0, 3) != 0);
            seg_left <= $urandom_range(0, 3);
          end
        endcase
        out_ready <= 1'b0;
      end
    end
  end

  task automatic send(acfm_pkg::action_e act, logic [acfm_pkg::SymW-1:0] sym,
                      logic [acfm_pkg::ValW-1:0] cnt, logic [acfm_pkg::ValW-1:0] val,
                      logic [acfm_pkg::ValW-1:0] lo, logic [acfm_pkg::ValW-1:0] hi);
    int gap;
    int pick;
    pick = $urandom_range(0, 99);
    gap = (pick < 55) ? 0 : (pick < 92) ? $urandom_range(1, 3) : $urandom_range(10, 40);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    action <= act;
    symbol <= sym;
    count <= cnt;
    code_value <= val;
    interval_low <= lo;
    interval_high <= hi;
    do @(posedge clk_i); while (!in_ready);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic set_scale(logic [acfm_pkg::ScaleW-1:0] v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [acfm_pkg::ValW-1:0] pick_count();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return 32'd1;
      3, 4: return $urandom;
      default: return $urandom_range(1, 5000);
    endcase
  endfunction

  function automatic logic [acfm_pkg::SymW-1:0] pick_symbol();
    if ($urandom_range(0, 9) == 0) return acfm_pkg::SymW'($urandom_range(NSym, 511));
    if ($urandom_range(0, 9) == 0) return acfm_pkg::SymW'(NSym - 1);
    return acfm_pkg::SymW'($urandom_range(0, NSym - 1));
  endfunction

  task automatic send_query();
    logic [acfm_pkg::ValW-1:0] lo, hi, val;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      send(acfm_pkg::ACT_LOAD, pick_symbol(), pick_count(), $urandom, $urandom, $urandom);
    end else if (pick < 50) begin
      send(acfm_pkg::ACT_RANGE, pick_symbol(), $urandom, $urandom, $urandom, $urandom);
    end else begin
      lo = $urandom;
      case ($urandom_range(0, 5))
        0: hi = $urandom;
        1: hi = lo + $urandom_range(0, 1000);
        default: hi = ($urandom_range(0, 1) != 0) ? '1 : lo + $urandom;
      endcase
      if (hi < lo && $urandom_range(0, 3) != 0) begin
        lo = '0;
      end
      case ($urandom_range(0, 7))
        0: val = lo;
        1: val = hi;
        2: val = $urandom;
        default: val = lo + (hi - lo) / 32'($urandom_range(1, 64)) * 32'($urandom_range(0, 1));
      endcase
      if ($urandom_range(0, 3) == 0)
        val = lo + $urandom_range(0, 32'hFFFF)
                   % (hi - lo + 1 == 0 ? 32'hFFFFFFFF : hi - lo + 1);
      send(acfm_pkg::ACT_DECODE, acfm_pkg::SymW'($urandom), $urandom, val, lo, hi);
    end
  endtask

  initial begin
    logic [acfm_pkg::ScaleW-1:0] scale_list [6];
    scale_list = '{30'd65535, 30'd1, 30'h3FFFFFFF, 30'd0, 30'd1000, 30'd4096};

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part
    set_scale(30'd65535);
    send(acfm_pkg::ACT_RANGE, 9'd0, '0, '0, '0, '0);
    send(acfm_pkg::ACT_DECODE, 9'd0, '0, 32'd5, '0, '1);
    send(acfm_pkg::ACT_BUILD, 9'd0, '0, '0, '0, '0);
    send(acfm_pkg::ACT_LOAD, 9'd0, '1, '0, '0, '0);
    send(acfm_pkg::ACT_LOAD, 9'(NSym - 1), 32'd1, '0, '0, '0);
    send(acfm_pkg::ACT_LOAD, 9'd300, '1, '0, '0, '0);
    send(acfm_pkg::ACT_LOAD, 9'd511, '1, '0, '0, '0);
    send(acfm_pkg::ACT_LOAD, 9'd0, '0, '0, '0, '0);
    send(acfm_pkg::ACT_LOAD, 9'd0, 32'd5, '0, '0, '0);
    send(acfm_pkg::ACT_LOAD, 9'd255, 32'd123456, '0, '0, '0);
    send(acfm_pkg::ACT_BUILD, 9'd0, '0, '0, '0, '0);
    send(acfm_pkg::ACT_RANGE, 9'd0, '0, '0, '0, '0);
    send(acfm_pkg::ACT_RANGE, 9'(NSym - 1), '0, '0, '0, '0);
    send(acfm_pkg::ACT_RANGE, 9'd511, '0, '0, '0, '0);
    send(acfm_pkg::ACT_DECODE, 9'd0, '0, '0, '0, '1);
    send(acfm_pkg::ACT_DECODE, 9'd0, '0, '1, '0, '1);
    send(acfm_pkg::ACT_DECODE, 9'd0, '0, 32'd10, 32'd100, 32'd20);
    send(acfm_pkg::ACT_DECODE, 9'd0, '0, 32'd7, 32'd500, 32'd600);
    send(acfm_pkg::ACT_LOAD, 9'd255, 32'd9, '0, '0, '0);
    send(acfm_pkg::ACT_RANGE, 9'd255, '0, '0, '0, '0);
    drain();

    // random batches: loads, a build, then queries
    for (int b = 0; b < 18; b++) begin
      if (b % 3 == 0) begin
        drain();
        set_scale((b == 15) ? 30'($urandom_range(1, 30'h3FFFFFFF)) : scale_list[b / 3]);
      end
      repeat ($urandom_range(5, 40)) send(acfm_pkg::ACT_LOAD, pick_symbol(), pick_count(),
                                          $urandom, $urandom, $urandom);
      send(acfm_pkg::ACT_BUILD, acfm_pkg::SymW'($urandom), $urandom, $urandom, $urandom,
           $urandom);
      repeat ($urandom_range(40, 80)) send_query();
    end

    // sum wraps past 40 bits, table overflows
    drain();
    set_scale(30'h3FFFFFFF);
    for (int s = 0; s < NSym; s++) send(acfm_pkg::ACT_LOAD, 9'(s), '1, '0, '0, '0);
    send(acfm_pkg::ACT_BUILD, 9'd0, '0, '0, '0, '0);
    repeat (40) send_query();

    // every count back to zero, build fails, queries refused
    for (int s = 0; s < NSym; s++) send(acfm_pkg::ACT_LOAD, 9'(s), '0, '0, '0, '0);
    send(acfm_pkg::ACT_BUILD, 9'd0, '0, '0, '0, '0);
    repeat (10) send_query();

    drain();
    repeat (200) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("PASS arith_coder_cumfreq_model");
    end else begin
      $display("FAIL arith_coder_cumfreq_model");
    end
    $finish;
  end

  initial begin
    #100ms;
    $display("FAIL arith_coder_cumfreq_model");
    $finish;
  end

endmodule
